@@ rtl/cpsc_pkg.sv @@
// Shared types and constants for the column projection segment counter.
// Word layouts, register indexes, controller/datapath handshake structs.
// No dependencies.
package cpsc_pkg;

    // Default sizing of the count memory and of the row range
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Fixed field widths
    localparam int PIX_W = 8;
    localparam int ROW_W = 10;
    localparam int COL_W = 10;
    localparam int END_W = 11;
    localparam int WID_W = 11;
    localparam int CNT_W = 11;
    localparam int GAP_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ROW         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd3;

    // Configuration reset values
    localparam logic [PIX_W-1:0] RST_PIXEL_THRESHOLD = 8'd128;
    localparam logic [ROW_W-1:0] RST_FIRST_ROW       = 10'd0;
    localparam logic [END_W-1:0] RST_END_ROW         = 11'd1024;
    localparam logic [WID_W-1:0] RST_IMAGE_WIDTH     = 11'd1024;

    // Input word modes
    localparam logic MODE_PIXEL   = 1'b0;
    localparam logic MODE_READOUT = 1'b1;

    // Saturation limits, gap divisor and gap counter start value
    localparam logic [CNT_W-1:0]        COUNT_MAX = 11'd2047;
    localparam logic signed [GAP_W-1:0] GAP_MAX   = 12'sd2047;
    localparam logic signed [GAP_W-1:0] GAP_INIT  = -12'sd1;
    localparam int                      GAP_DIV   = 10;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } in_word_t;

    typedef struct packed {
        logic [COL_W-1:0]        column_index;
        logic [CNT_W-1:0]        column_count;
        logic signed [GAP_W-1:0] letter_count;
        logic                    last;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;     // write zero at the sweep address and advance
        logic load_item;  // capture the accepted word
        logic exec_en;    // update the count, the gap state and the output
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is at the final entry
        logic is_readout; // captured word is a readout
        logic out_busy;   // output register holds a word that is stalled
    } dp_status_t;

endpackage

@@ rtl/cpsc_ctrl.sv @@
// Controller of the column projection segment counter.
// Sequences the clearing sweep and the read-modify-write of each word.
// Depends on cpsc_pkg.
module cpsc_ctrl
    import cpsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_EXEC   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold a readout until the output register is free
                if (!(status.is_readout && status.out_busy))
                begin
                    cmd.exec_en = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/cpsc_dpath.sv @@
// Datapath of the column projection segment counter: configuration registers,
// band threshold pipeline, column count memory, gap counter and output register.
// Depends on cpsc_pkg.
module cpsc_dpath
    import cpsc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output out_word_t             out_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WNEED = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WNEED > WID_W) ? WNEED : WID_W;
    localparam int HNEED = $clog2(MAX_HEIGHT + 1);
    localparam int HW    = (HNEED > END_W) ? HNEED : END_W;
    // floor(h / 10) by reciprocal: estimate is exact or one low
    localparam int SH    = HW + 4;
    localparam int RECIP = (2 ** SH) / GAP_DIV;
    localparam int KW    = SH - 3;
    localparam int PW    = HW + KW;
    localparam int QW    = PW - SH;

    // Configuration registers
    logic [PIX_W-1:0] threshold_reg;
    logic [ROW_W-1:0] first_row_reg;
    logic [END_W-1:0] end_row_reg;
    logic [WID_W-1:0] image_width_reg;

    // Band threshold pipeline
    logic [HW-1:0] bend;
    logic [HW-1:0] first_ext;
    logic [HW-1:0] height_next;
    logic [HW-1:0] height_reg;
    logic [PW-1:0] prod_next;
    logic [PW-1:0] prod_reg;
    logic [QW-1:0] quot;
    logic [HW-1:0] quot_ext;
    logic [HW-1:0] rem;
    logic [HW-1:0] thr_next;
    logic [HW-1:0] thr_reg;

    // Column bounds
    logic [CMPW-1:0] width_eff;
    logic [CMPW-1:0] col_ext;
    logic [HW-1:0]   row_ext;
    logic            hit_next;
    logic [AW-1:0]   rcol_clamp;

    // Captured word
    logic          mode_reg;
    logic          hit_reg;
    logic [AW-1:0] addr_reg;

    // Count memory
    logic [CNT_W-1:0] count_mem [MAX_WIDTH];
    logic [CNT_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic [AW-1:0]    clr_addr_reg;

    // Readout state
    logic [AW-1:0]           rcol_reg;
    logic                    armed_reg;
    logic signed [GAP_W-1:0] gap_reg;
    logic [HW-1:0]           cnt_ext;
    logic                    dense;
    logic                    gap_hit;
    logic signed [GAP_W-1:0] gap_next;
    logic                    is_last;

    // Output register
    logic      out_valid_reg;
    out_word_t out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= RST_PIXEL_THRESHOLD;
            first_row_reg   <= RST_FIRST_ROW;
            end_row_reg     <= RST_END_ROW;
            image_width_reg <= RST_IMAGE_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_THRESHOLD: threshold_reg   <= cfg_data[PIX_W-1:0];
                CFG_FIRST_ROW:       first_row_reg   <= cfg_data[ROW_W-1:0];
                CFG_END_ROW:         end_row_reg     <= cfg_data[END_W-1:0];
                CFG_IMAGE_WIDTH:     image_width_reg <= cfg_data[WID_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp width and band end to the memory and row limits
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = CMPW'(1);
        end
        else if (CMPW'(image_width_reg) > CMPW'(MAX_WIDTH))
        begin
            width_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CMPW'(image_width_reg);
        end

        if (HW'(end_row_reg) > HW'(MAX_HEIGHT))
        begin
            bend = HW'(MAX_HEIGHT);
        end
        else
        begin
            bend = HW'(end_row_reg);
        end
        first_ext   = HW'(first_row_reg);
        height_next = (bend > first_ext) ? (bend - first_ext) : '0;
    end

    // Divide band height by ten: multiply, then correct by one
    assign prod_next = PW'(height_reg) * PW'(RECIP);
    assign quot      = prod_reg[PW-1:SH];
    assign quot_ext  = HW'(quot);
    assign rem       = height_reg - quot_ext * HW'(GAP_DIV);
    assign thr_next  = (rem >= HW'(GAP_DIV)) ? (quot_ext + HW'(1)) : quot_ext;

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        prod_reg   <= prod_next;
        thr_reg    <= thr_next;
    end

    // Qualify an incoming pixel and clamp the readout column
    assign col_ext  = CMPW'(in_data.col);
    assign row_ext  = HW'(in_data.row);
    assign hit_next = (col_ext < width_eff) && (row_ext >= first_ext) &&
                      (row_ext < bend) && (in_data.pixel < threshold_reg);
    assign rcol_clamp = (CMPW'(rcol_reg) >= width_eff) ? AW'(width_eff - CMPW'(1))
                                                       : rcol_reg;

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= in_data.mode;
            hit_reg  <= hit_next;
            addr_reg <= (in_data.mode == MODE_READOUT) ? rcol_clamp : AW'(col_ext);
        end
    end

    // Gap detection on the column read back
    assign cnt_ext = HW'(rd_data_reg);
    assign dense   = (rd_data_reg != '0) && (cnt_ext >= thr_reg);
    assign gap_hit = (cnt_ext < thr_reg) && armed_reg;
    assign gap_next = (gap_hit && (gap_reg < GAP_MAX)) ? (gap_reg + 12'sd1) : gap_reg;
    assign is_last  = (CMPW'(addr_reg) + CMPW'(1)) >= width_eff;

    // Count memory write: sweep, readout clear or pixel increment
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clr_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end
        else if (cmd.exec_en)
        begin
            if (mode_reg == MODE_READOUT)
            begin
                mem_we = 1'b1;
            end
            else if (hit_reg && (rd_data_reg != COUNT_MAX))
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= count_mem[addr_reg];
    end

    // Advance the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Update the readout position and the gap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcol_reg  <= '0;
            armed_reg <= 1'b1;
            gap_reg   <= GAP_INIT;
        end
        else if (cmd.exec_en && (mode_reg == MODE_READOUT))
        begin
            if (is_last)
            begin
                rcol_reg  <= '0;
                armed_reg <= 1'b1;
                gap_reg   <= GAP_INIT;
            end
            else
            begin
                rcol_reg <= addr_reg + AW'(1);
                gap_reg  <= gap_next;
                if (gap_hit)
                begin
                    armed_reg <= 1'b0;
                end
                else if (dense)
                begin
                    armed_reg <= 1'b1;
                end
            end
        end
    end

    // Load the output register; drop valid once the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec_en && (mode_reg == MODE_READOUT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_en && (mode_reg == MODE_READOUT))
        begin
            out_data_reg.column_index <= COL_W'(addr_reg);
            out_data_reg.column_count <= rd_data_reg;
            out_data_reg.letter_count <= gap_next;
            out_data_reg.last         <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.clr_last   = (clr_addr_reg == AW'(MAX_WIDTH - 1));
    assign status.is_readout = (mode_reg == MODE_READOUT);
    assign status.out_busy   = out_valid_reg && out_stall;

endmodule

@@ rtl/column_projection_segment_counter_top.sv @@
// Column projection segment counter, top level: controller plus datapath.
// Depends on cpsc_pkg, cpsc_ctrl and cpsc_dpath.
//
// After reset the block sweeps its column count memory to zero, one entry per
// cycle, with in_stall high; configuration writes are taken during the sweep.
// Each input word then occupies the block through the accept, a registered
// read of the count memory, a step for the band threshold (height / 10)
// pipeline, and the update that writes the count back. The registered read
// of the count memory sets this sequence. A readout word also waits in the
// update step while a previous result sits stalled in the output register;
// pixel words give no result.
// A result appears on out_valid the cycle after its update and stays until
// taken, while the next input word is already being worked on.
module column_projection_segment_counter_top
    import cpsc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence each word
    cpsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold counts, threshold and gap state
    cpsc_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ sim/column_projection_segment_counter_top_test.sv @@
// Self-checking testbench for column_projection_segment_counter_top.
// Sends pixel and readout words, predicts each column result, compares fields.
// Depends on cpsc_pkg and the column_projection_segment_counter_top RTL.
module column_projection_segment_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsc_pkg::*;

    localparam int MAX_COLS       = DEF_MAX_WIDTH;
    localparam int MAX_ROWS       = DEF_MAX_HEIGHT;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_WORDS   = 600;
    localparam int SWEEP_PIXELS   = 100;

    // Column projection predictor and queue of pending column results
    class projection_scoreboard;
        logic [CNT_W-1:0]        col_count [MAX_COLS];
        int unsigned             next_col;
        bit                      armed;
        logic signed [GAP_W-1:0] gaps;
        logic [PIX_W-1:0]        threshold;
        logic [ROW_W-1:0]        first_row;
        logic [END_W-1:0]        end_row;
        logic [WID_W-1:0]        width_reg;
        out_word_t               pending_results [$];
        int                      errors;
        int                      results;
        int                      sweeps;
        int                      words;
        int                      max_gap;

        function new();
            foreach (col_count[i])
                col_count[i] = '0;
            next_col  = 0;
            armed     = 1'b1;
            gaps      = GAP_INIT;
            threshold = RST_PIXEL_THRESHOLD;
            first_row = RST_FIRST_ROW;
            end_row   = RST_END_ROW;
            width_reg = RST_IMAGE_WIDTH;
            errors    = 0;
            results   = 0;
            sweeps    = 0;
            words     = 0;
            max_gap   = -1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PIXEL_THRESHOLD: threshold = value[PIX_W-1:0];
                CFG_FIRST_ROW:       first_row = value[ROW_W-1:0];
                CFG_END_ROW:         end_row   = value[END_W-1:0];
                CFG_IMAGE_WIDTH:     width_reg = value[WID_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulate a pixel, or walk one column and queue its result
        function void note_input(in_word_t word);
            int unsigned width;
            int unsigned bend;
            int unsigned height;
            int unsigned gap_thr;
            int unsigned c;
            int unsigned cnt;
            out_word_t   want;
            words++;
            width = (width_reg == 0) ? 1 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
            bend  = (end_row > MAX_ROWS) ? MAX_ROWS : end_row;
            if (word.mode == MODE_PIXEL)
            begin
                if (word.col < width && word.row >= first_row && word.row < bend &&
                    word.pixel < threshold && col_count[word.col] != COUNT_MAX)
                    col_count[word.col]++;
                return;
            end
            c = (next_col >= width) ? width - 1 : next_col;
            height  = (bend > first_row) ? bend - first_row : 0;
            gap_thr = height / GAP_DIV;
            cnt = col_count[c];
            col_count[c] = '0;
            // Dense column arms, light column while armed counts a gap and disarms
            if (cnt > 0 && cnt >= gap_thr)
                armed = 1'b1;
            if (cnt < gap_thr && armed)
            begin
                if (gaps != GAP_MAX)
                    gaps++;
                armed = 1'b0;
            end
            want.column_index = COL_W'(c);
            want.column_count = CNT_W'(cnt);
            want.letter_count = gaps;
            want.last         = (c + 1 >= width);
            pending_results.push_back(want);
            if (int'(gaps) > max_gap)
                max_gap = int'(gaps);
            if (want.last)
            begin
                next_col = 0;
                gaps     = GAP_INIT;
                armed    = 1'b1;
                sweeps++;
            end
            else
                next_col = c + 1;
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, int got, int want, int col);
            if (got != want)
                report_mismatch($sformatf("column %0d %s: got %0d, want %0d",
                                          col, name, got, want));
        endtask

        // Compare an accepted result word with the oldest pending one
        task check_result(out_word_t got);
            out_word_t want;
            results++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word %h", got));
                return;
            end
            want = pending_results.pop_front();
            if ($isunknown(got))
                report_mismatch($sformatf("result word has unknown bits: %h", got));
            compare_field("column_index", int'(got.column_index), int'(want.column_index),
                          int'(want.column_index));
            compare_field("column_count", int'(got.column_count), int'(want.column_count),
                          int'(want.column_index));
            compare_field("letter_count", int'(got.letter_count), int'(want.letter_count),
                          int'(want.column_index));
            compare_field("last", int'(got.last), int'(want.last), int'(want.column_index));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_word_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;

    projection_scoreboard sb;
    bit                   hold_request = 1'b0;
    int                   burst_left   = 0;

    // Configuration as seen by the stimulus generator
    int unsigned cur_thr   = RST_PIXEL_THRESHOLD;
    int unsigned cur_first = RST_FIRST_ROW;
    int unsigned cur_bend  = RST_END_ROW;
    int unsigned cur_eff_w = RST_IMAGE_WIDTH;

    column_projection_segment_counter_top #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Track accepted words on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (in_valid && !in_stall)
                sb.note_input(in_data);
        end
    end

    // Stall the result channel on a changing pattern, or hold off on request
    initial
    begin : receiver
        int style;
        int style_left;
        int hold_left;
        style      = 0;
        style_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(8, 80);
                end
                style_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // End the run when no word moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("column_projection_segment_counter_top_test NOT OK");
        $finish;
    end

    function automatic in_word_t make_word(logic mode, logic [PIX_W-1:0] pixel,
                                           logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        in_word_t w;
        w.mode  = mode;
        w.pixel = pixel;
        w.row   = row;
        w.col   = col;
        return w;
    endfunction

    // Random pixel word: in width, in band and mostly dark, or pure noise
    function automatic in_word_t random_pixel(bit well_formed);
        in_word_t w;
        w = in_word_t'($urandom);
        if (well_formed)
        begin
            w.mode = MODE_PIXEL;
            w.col  = COL_W'($urandom_range(0, cur_eff_w - 1));
            if (cur_bend > cur_first)
                w.row = ROW_W'($urandom_range(cur_first, cur_bend - 1));
            if (cur_thr != 0 && $urandom_range(0, 7) != 0)
                w.pixel = PIX_W'($urandom_range(0, cur_thr - 1));
        end
        return w;
    endfunction

    // Offer one word in bursts with random gaps, hold it until taken
    task automatic send_word(input in_word_t w);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_readouts(input int unsigned n);
        repeat (n)
            send_word(make_word(MODE_READOUT, PIX_W'($urandom), ROW_W'($urandom),
                                COL_W'($urandom)));
    endtask

    // Stop offering, wait for every result, then let a last pixel word finish
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        sb.write_reg(idx, value[CFG_DATA_W-1:0]);
        @(posedge clk);
    endtask

    task automatic set_config(input int unsigned thr_v, input int unsigned first_v,
                              input int unsigned stop_v, input int unsigned width_v);
        drain();
        put_reg(CFG_PIXEL_THRESHOLD, thr_v);
        put_reg(CFG_FIRST_ROW, first_v);
        put_reg(CFG_END_ROW, stop_v);
        put_reg(CFG_IMAGE_WIDTH, width_v);
        cfg_we    <= 1'b0;
        cur_thr   = thr_v;
        cur_first = first_v;
        cur_bend  = (stop_v > MAX_ROWS) ? MAX_ROWS : stop_v;
        cur_eff_w = (width_v == 0) ? 1 : (width_v > MAX_COLS) ? MAX_COLS : width_v;
    endtask

    initial
    begin : stimulus
        int unsigned n;
        int unsigned frame;
        int unsigned random_words;
        int unsigned thr_v;
        int unsigned first_v;
        int unsigned stop_v;
        int unsigned width_v;
        bit          well;
        frame        = 0;
        random_words = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: field extremes, dark and light pixels
        send_word(make_word(MODE_PIXEL, 8'd0, 10'd0, 10'd0));
        send_word(make_word(MODE_PIXEL, 8'd127, 10'd1023, 10'd1023));
        send_word(make_word(MODE_PIXEL, 8'd128, 10'd0, 10'd0));
        send_word(make_word(MODE_PIXEL, 8'd255, 10'd1023, 10'd0));
        send_readouts(3);

        // Lower the width below the walk position: next readout ends the sweep
        set_config(128, 0, 1024, 2);
        send_readouts(1);

        // Threshold zero, empty band, width zero acting as one column
        set_config(0, 5, 0, 0);
        send_word(make_word(MODE_PIXEL, 8'd0, 10'd5, 10'd0));
        send_readouts(2);

        // One-row band at the last row, single column
        set_config(255, 1023, 1024, 1);
        send_word(make_word(MODE_PIXEL, 8'd254, 10'd1023, 10'd0));
        send_word(make_word(MODE_PIXEL, 8'd255, 10'd1023, 10'd0));
        send_word(make_word(MODE_PIXEL, 8'd0, 10'd1022, 10'd0));
        send_word(make_word(MODE_PIXEL, 8'd0, 10'd1023, 10'd1));
        send_readouts(1);

        // Short gap sequence: dense, light, dense, light
        set_config(200, 0, 20, 4);
        repeat (3) send_word(make_word(MODE_PIXEL, 8'd10, 10'd3, 10'd0));
        repeat (2) send_word(make_word(MODE_PIXEL, 8'd199, 10'd19, 10'd2));
        send_readouts(4);

        // Full-width sweep with oversized end row and width
        set_config(255, 1000, 2047, 2047);
        repeat (SWEEP_PIXELS) send_word(random_pixel(1'b1));
        send_readouts(MAX_COLS);

        // Random frames: configure, scatter pixels, walk the columns
        while (random_words < RANDOM_WORDS)
        begin
            frame++;
            case ($urandom_range(0, 9))
                0:       thr_v = 0;
                1:       thr_v = 255;
                default: thr_v = $urandom_range(1, 254);
            endcase
            first_v = $urandom_range(0, 1023);
            case ($urandom_range(0, 9))
                0:       stop_v = $urandom_range(0, first_v);
                1:       stop_v = $urandom_range(first_v + 1, 2047);
                default: stop_v = first_v + $urandom_range(1, 60);
            endcase
            case ($urandom_range(0, 19))
                0:       width_v = 0;
                1:       width_v = $urandom_range(13, 2047);
                default: width_v = $urandom_range(1, 12);
            endcase
            set_config(thr_v, first_v, stop_v, width_v);

            n = cur_eff_w * $urandom_range(0, 5);
            if (n > 80)
                n = 80;
            repeat (n)
            begin
                well = ($urandom_range(0, 9) != 0);
                send_word(random_pixel(well));
                if (well)
                    random_words++;
            end

            // Walk a full sweep mostly, sometimes a partial or overlong one
            if (cur_eff_w > 16)
                n = $urandom_range(1, 20);
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(0, 2 * cur_eff_w);
            else
                n = cur_eff_w;
            // Hold off the result side once so readout words back up
            if (frame == 3)
            begin
                hold_request = 1'b1;
                if (n < 12)
                    n = 12;
            end
            send_readouts(n);
            random_words += n;
        end

        drain();
        $display("Run covered %0d input words (%0d random) in %0d frames, %0d column results.",
                 sb.words, random_words, frame, sb.results);
        $display("Completed %0d sweeps, highest letter count %0d, one full 1024-column sweep.",
                 sb.sweeps, sb.max_gap);
        if (sb.errors == 0)
            $display("column_projection_segment_counter_top_test OK");
        else
            $display("column_projection_segment_counter_top_test NOT OK");
        $finish;
    end

endmodule
